### rtl/lrsi_pkg.sv
// package for the line, ray and segment intersection block
`default_nettype none
package lrsi_pkg;
    localparam int CoordBits = 16;
    localparam int NumBits   = 50;
    localparam int DenBits   = 34;
    // eight coordinates in tdata, the two kinds travel in tuser
    localparam int InBits    = 8 * 16;
    localparam int InBytes   = (InBits + 7) / 8;
    localparam int OutBits   = NumBits * 2 + DenBits;
    localparam int OutBytes  = (OutBits + 7) / 8;
    typedef enum logic [1:0] {
        K_LINE = 2'd0,
        K_RAY  = 2'd1,
        K_SEG  = 2'd2,
        K_SEG3 = 2'd3
    } t_kind;
endpackage
`default_nettype wire

### rtl/line_ray_segment_intersection.sv
// top level: pipelined intersection of two lines, rays or segments
//  channel | dir | tdata fields (low first)                  | tuser (low first)
//  s_axis  | in  | first ax,ay,bx,by, second ax,ay,bx,by     | first kind, second kind
//  m_axis  | out | x_numer, y_numer, denom                   | has_point, infinite
// five register stages, one word per cycle while m_axis does not stall
// stage 1: A, B and C products; stage 2: C and denominator products;
// stage 3: numerator and collinear products, denominator; stage 4: sign fix and
// scaled extent bounds; stage 5: compares and output register
// i_rst_n synchronous active low clears valid bits only
// a stall of m_axis freezes every stage together; nothing is lost or repeated
`default_nettype none
module line_ray_segment_intersection
    import lrsi_pkg::*;
#(
    parameter int COORD_BITS = CoordBits
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // first ax, ay, bx, by, second ax, ay, bx, by
    input  wire logic [InBytes*8-1:0]    s_axis_tdata,
    // first kind, second kind
    input  wire logic [3:0]              s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // x_numer, y_numer, denom, zero fill
    output logic [OutBytes*8-1:0]        m_axis_tdata,
    // has_point, infinite
    output logic [1:0]                   m_axis_tuser
);
    localparam int W  = COORD_BITS;
    localparam int W1 = W + 1;        // differences
    localparam int W2 = 2 * W + 2;    // products and C
    localparam int W3 = 3 * W + 4;    // numerators
    localparam int WC = W2 + W + 2;   // collinear checks and scaled bounds

    logic en;
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    // field unpack
    logic [1:0] k0, k1;
    logic signed [W-1:0] ax0, ay0, bx0, by0, ax1, ay1, bx1, by1;
    always_comb begin
        k0  = s_axis_tuser[1:0];
        ax0 = W'(s_axis_tdata[15:0]);    ay0 = W'(s_axis_tdata[31:16]);
        bx0 = W'(s_axis_tdata[47:32]);   by0 = W'(s_axis_tdata[63:48]);
        k1  = s_axis_tuser[3:2];
        ax1 = W'(s_axis_tdata[79:64]);   ay1 = W'(s_axis_tdata[95:80]);
        bx1 = W'(s_axis_tdata[111:96]);  by1 = W'(s_axis_tdata[127:112]);
    end

    // per object registered state through the pipe
    typedef struct packed {
        logic [1:0] k;
        logic signed [W-1:0] ax, ay, bx, by;
    } t_obj;

    // stage 1: A, B and the two C products
    logic [4:0] r_v;
    t_obj r_s1_p, r_s1_q;
    logic signed [W1-1:0] r_s1_ap, r_s1_bp, r_s1_aq, r_s1_bq;
    logic signed [W2-1:0] r_s1_c1p, r_s1_c2p, r_s1_c1q, r_s1_c2q;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_p <= '{k0, ax0, ay0, bx0, by0};
            r_s1_q <= '{k1, ax1, ay1, bx1, by1};
            r_s1_ap <= W1'(by0) - W1'(ay0);
            r_s1_bp <= W1'(ax0) - W1'(bx0);
            r_s1_aq <= W1'(by1) - W1'(ay1);
            r_s1_bq <= W1'(ax1) - W1'(bx1);
            r_s1_c1p <= W2'(bx0) * W2'(ay0);
            r_s1_c2p <= W2'(ax0) * W2'(by0);
            r_s1_c1q <= W2'(bx1) * W2'(ay1);
            r_s1_c2q <= W2'(ax1) * W2'(by1);
        end
    end

    // stage 2: C and the denominator products
    t_obj r_s2_p, r_s2_q;
    logic signed [W1-1:0] r_s2_ap, r_s2_bp, r_s2_aq, r_s2_bq;
    logic signed [W2-1:0] r_s2_cp, r_s2_cq, r_s2_m1, r_s2_m2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_p <= r_s1_p; r_s2_q <= r_s1_q;
            r_s2_ap <= r_s1_ap; r_s2_bp <= r_s1_bp;
            r_s2_aq <= r_s1_aq; r_s2_bq <= r_s1_bq;
            r_s2_cp <= r_s1_c1p - r_s1_c2p;
            r_s2_cq <= r_s1_c1q - r_s1_c2q;
            r_s2_m1 <= W2'(r_s1_ap) * W2'(r_s1_bq);
            r_s2_m2 <= W2'(r_s1_aq) * W2'(r_s1_bp);
        end
    end

    // stage 3: numerator products, collinear products, denominator
    t_obj r_s3_p, r_s3_q;
    logic r_s3_degen, r_s3_vert;
    logic signed [W2-1:0] r_s3_d;
    logic signed [WC-1:0] r_s3_x1, r_s3_x2, r_s3_y1, r_s3_y2, r_s3_s1, r_s3_s2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_p <= r_s2_p; r_s3_q <= r_s2_q;
            r_s3_degen <= (r_s2_ap == '0 && r_s2_bp == '0) ||
                          (r_s2_aq == '0 && r_s2_bq == '0);
            r_s3_vert <= (r_s2_bp == '0);
            r_s3_d <= r_s2_m1 - r_s2_m2;
            r_s3_x1 <= WC'(r_s2_cq) * WC'(r_s2_bp);
            r_s3_x2 <= WC'(r_s2_cp) * WC'(r_s2_bq);
            r_s3_y1 <= WC'(r_s2_cp) * WC'(r_s2_aq);
            r_s3_y2 <= WC'(r_s2_cq) * WC'(r_s2_ap);
            r_s3_s1 <= (r_s2_bp != '0) ? WC'(r_s2_bp) * WC'(r_s2_cq)
                                       : WC'(r_s2_ap) * WC'(r_s2_cq);
            r_s3_s2 <= (r_s2_bp != '0) ? WC'(r_s2_cp) * WC'(r_s2_bq)
                                       : WC'(r_s2_cp) * WC'(r_s2_aq);
        end
    end

    // stage 4 front: sign fix, then scaled extent bounds
    logic signed [W3-1:0] xn3, yn3;
    logic signed [W2-1:0] d3;
    always_comb begin
        xn3 = W3'(r_s3_x1) - W3'(r_s3_x2);
        yn3 = W3'(r_s3_y1) - W3'(r_s3_y2);
        d3  = r_s3_d;
        if (r_s3_d < 0) begin
            xn3 = -xn3; yn3 = -yn3; d3 = -r_s3_d;
        end
    end

    // per object extent data in scaled form
    t_obj r_s4_p, r_s4_q;
    logic r_s4_degen, r_s4_vert, r_s4_par, r_s4_same;
    logic signed [W3-1:0] r_s4_xn, r_s4_yn;
    logic signed [W2-1:0] r_s4_d;
    logic signed [WC-1:0] r_s4_pax, r_s4_pay, r_s4_pbx, r_s4_pby;
    logic signed [WC-1:0] r_s4_qax, r_s4_qay, r_s4_qbx, r_s4_qby;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_p <= r_s3_p; r_s4_q <= r_s3_q;
            r_s4_degen <= r_s3_degen; r_s4_vert <= r_s3_vert;
            r_s4_par <= (r_s3_d == '0);
            r_s4_same <= (r_s3_s1 == r_s3_s2);
            r_s4_xn <= xn3; r_s4_yn <= yn3; r_s4_d <= d3;
            r_s4_pax <= WC'(r_s3_p.ax) * WC'(d3); r_s4_pay <= WC'(r_s3_p.ay) * WC'(d3);
            r_s4_pbx <= WC'(r_s3_p.bx) * WC'(d3); r_s4_pby <= WC'(r_s3_p.by) * WC'(d3);
            r_s4_qax <= WC'(r_s3_q.ax) * WC'(d3); r_s4_qay <= WC'(r_s3_q.ay) * WC'(d3);
            r_s4_qbx <= WC'(r_s3_q.bx) * WC'(d3); r_s4_qby <= WC'(r_s3_q.by) * WC'(d3);
        end
    end

    // extent test of a crossing point against one object
    function automatic logic f_within(input t_obj o, input logic signed [WC-1:0] sax,
            input logic signed [WC-1:0] say, input logic signed [WC-1:0] sbx,
            input logic signed [WC-1:0] sby, input logic signed [W3-1:0] xn,
            input logic signed [W3-1:0] yn);
        logic a_first;
        logic signed [W3:0] xe, ye;
        a_first = (o.ax < o.bx) || (o.ax == o.bx && o.ay < o.by);
        xe = (W3+1)'(xn);
        ye = (W3+1)'(yn);
        case (o.k)
            K_LINE: f_within = 1'b1;
            K_RAY: begin
                if (o.ax == o.bx)
                    f_within = (o.ay < o.by) ? ((W3+1)'(say) <= ye) : ((W3+1)'(say) >= ye);
                else
                    f_within = (o.ax < o.bx) ? ((W3+1)'(sax) <= xe) : ((W3+1)'(sax) >= xe);
            end
            default: begin
                if (o.ax == o.bx)
                    f_within = a_first
                        ? ((W3+1)'(say) <= ye && ye <= (W3+1)'(sby))
                        : ((W3+1)'(sby) <= ye && ye <= (W3+1)'(say));
                else
                    f_within = a_first
                        ? ((W3+1)'(sax) <= xe && xe <= (W3+1)'(sbx))
                        : ((W3+1)'(sbx) <= xe && xe <= (W3+1)'(sax));
            end
        endcase
    endfunction

    // collinear overlap of two rays or segments
    logic c_inf, c_pt;
    logic signed [W-1:0] c_x, c_y;
    always_comb begin
        logic signed [W-1:0] pta, ptb, qta, qtb;
        logic ph, pl, qh, ql, rl, rh;
        logic signed [W-1:0] plo, phi, qlo, qhi, rlo, rhi;
        logic signed [W-1:0] plx, ply, phx, phy, qlx, qly, qhx, qhy;
        logic signed [W-1:0] rlx, rly, rhx, rhy;
        pta = r_s4_vert ? r_s4_p.ay : r_s4_p.ax; ptb = r_s4_vert ? r_s4_p.by : r_s4_p.bx;
        qta = r_s4_vert ? r_s4_q.ay : r_s4_q.ax; qtb = r_s4_vert ? r_s4_q.by : r_s4_q.bx;
        pl = 1'b1; ph = 1'b1; ql = 1'b1; qh = 1'b1;
        if (pta <= ptb) begin
            plo = pta; plx = r_s4_p.ax; ply = r_s4_p.ay;
            phi = ptb; phx = r_s4_p.bx; phy = r_s4_p.by;
        end else begin
            plo = ptb; plx = r_s4_p.bx; ply = r_s4_p.by;
            phi = pta; phx = r_s4_p.ax; phy = r_s4_p.ay;
        end
        if (qta <= qtb) begin
            qlo = qta; qlx = r_s4_q.ax; qly = r_s4_q.ay;
            qhi = qtb; qhx = r_s4_q.bx; qhy = r_s4_q.by;
        end else begin
            qlo = qtb; qlx = r_s4_q.bx; qly = r_s4_q.by;
            qhi = qta; qhx = r_s4_q.ax; qhy = r_s4_q.ay;
        end
        if (r_s4_p.k == K_RAY) begin
            if (pta < ptb) ph = 1'b0; else pl = 1'b0;
        end
        if (r_s4_q.k == K_RAY) begin
            if (qta < qtb) qh = 1'b0; else ql = 1'b0;
        end
        rl = pl; rlo = plo; rlx = plx; rly = ply;
        rh = ph; rhi = phi; rhx = phx; rhy = phy;
        if (!pl || (ql && qlo > plo)) begin
            rl = ql; rlo = qlo; rlx = qlx; rly = qly;
        end
        if (!ph || (qh && qhi < phi)) begin
            rh = qh; rhi = qhi; rhx = qhx; rhy = qhy;
        end
        c_inf = !rl || !rh || rlo < rhi;
        c_pt  = !c_inf && rlo == rhi;
        c_x = rlx;
        c_y = rly;
        if (r_s4_p.k == K_LINE || r_s4_q.k == K_LINE) begin
            c_inf = 1'b1; c_pt = 1'b0;
        end
    end

    // stage 5: decision and output register
    logic r_hp, r_inf;
    logic [NumBits-1:0] r_xn, r_yn;
    logic [DenBits-1:0] r_d;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hp <= 1'b0; r_inf <= 1'b0;
            r_xn <= '0; r_yn <= '0; r_d <= '0;
            if (!r_s4_degen) begin
                if (!r_s4_par) begin
                    if (f_within(r_s4_p, r_s4_pax, r_s4_pay, r_s4_pbx, r_s4_pby,
                                 r_s4_xn, r_s4_yn) &&
                        f_within(r_s4_q, r_s4_qax, r_s4_qay, r_s4_qbx, r_s4_qby,
                                 r_s4_xn, r_s4_yn)) begin
                        r_hp <= 1'b1;
                        r_xn <= NumBits'(r_s4_xn);
                        r_yn <= NumBits'(r_s4_yn);
                        r_d  <= DenBits'(r_s4_d);
                    end
                end else if (r_s4_same) begin
                    r_inf <= c_inf;
                    if (c_pt) begin
                        r_hp <= 1'b1;
                        r_xn <= NumBits'(c_x);
                        r_yn <= NumBits'(c_y);
                        r_d  <= DenBits'(1);
                    end
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[3:0], s_axis_tvalid};
        end
    end

    assign m_axis_tvalid = r_v[4];
    assign m_axis_tdata  = {(OutBytes*8-OutBits)'(0), r_d, r_yn, r_xn};
    assign m_axis_tuser  = {r_inf, r_hp};
endmodule
`default_nettype wire

### rtl/lrsi_checker.sv
// port checker for the intersection block
`default_nettype none
module lrsi_checker
    import lrsi_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [OutBytes*8-1:0] m_axis_tdata,
    input wire logic [1:0]           m_axis_tuser
);
    // no point means all result fields are zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0) else $error("nonzero");
    // a point and the infinite flag never come together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1])) else $error("both");
    // a point carries a nonzero denominator
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[133:100] != '0) else $error("den");
    // ready follows the output side
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready) else $error("ready");
    // stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("hold");
endmodule

bind line_ray_segment_intersection lrsi_checker u_lrsi_checker (.*);
`default_nettype wire

### tb/tb_lrsi_checker.sv
// checker for the intersection block: predicts and compares every output word
`timescale 1ns / 100ps
`default_nettype none
module tb_lrsi_checker
    import lrsi_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_ready,
    input  wire logic [InBytes*8-1:0]   i_in_data,
    input  wire logic [3:0]             i_in_user,
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_ready,
    input  wire logic [OutBytes*8-1:0]  i_out_data,
    input  wire logic [1:0]             i_out_user,
    output int                          o_fail_count,
    output int                          o_pending
);
    typedef struct packed {
        logic                hit;
        logic                endless;
        logic [NumBits-1:0]  xn;
        logic [NumBits-1:0]  yn;
        logic [DenBits-1:0]  den;
    } t_crossing;

    typedef struct {
        t_kind       kind;
        longint      ax, ay, bx, by, a, b, c;
    } t_shape;

    typedef struct {
        bit     has_lo, has_hi;
        longint lo, hi, lo_x, lo_y, hi_x, hi_y;
    } t_extent;

    t_crossing crossings_due[$];

    // unpack one object from its kind and four coordinates
    function automatic t_shape shape_from(logic [65:0] f);
        t_shape s;
        s.kind = t_kind'(f[1:0]);
        s.ax = longint'(signed'(f[17:2]));
        s.ay = longint'(signed'(f[33:18]));
        s.bx = longint'(signed'(f[49:34]));
        s.by = longint'(signed'(f[65:50]));
        s.a = s.by - s.ay;
        s.b = s.ax - s.bx;
        s.c = s.bx * s.ay - s.ax * s.by;
        return s;
    endfunction

    // is the point xn/d, yn/d on the object
    function automatic bit on_shape(t_shape s, longint xn, longint yn, longint d);
        bit     fwd;
        longint sx, sy, ex, ey;
        if (s.kind == K_LINE) return 1;
        if (s.kind == K_RAY) begin
            if (s.ax == s.bx) return (s.ay < s.by) ? (s.ay * d <= yn) : (s.ay * d >= yn);
            return (s.ax < s.bx) ? (s.ax * d <= xn) : (s.ax * d >= xn);
        end
        fwd = (s.ax < s.bx) || (s.ax == s.bx && s.ay < s.by);
        sx = fwd ? s.ax : s.bx;
        sy = fwd ? s.ay : s.by;
        ex = fwd ? s.bx : s.ax;
        ey = fwd ? s.by : s.ay;
        if (sx == ex) return sy * d <= yn && yn <= ey * d;
        return sx * d <= xn && xn <= ex * d;
    endfunction

    function automatic t_extent extent_of(t_shape s, bit vert);
        t_extent e;
        longint  ta, tb;
        ta = vert ? s.ay : s.ax;
        tb = vert ? s.by : s.bx;
        e.has_lo = 1;
        e.has_hi = 1;
        if (ta <= tb) begin
            e.lo = ta; e.lo_x = s.ax; e.lo_y = s.ay;
            e.hi = tb; e.hi_x = s.bx; e.hi_y = s.by;
        end else begin
            e.lo = tb; e.lo_x = s.bx; e.lo_y = s.by;
            e.hi = ta; e.hi_x = s.ax; e.hi_y = s.ay;
        end
        if (s.kind == K_RAY) begin
            if (ta < tb) e.has_hi = 0;
            else e.has_lo = 0;
        end
        return e;
    endfunction

    function automatic t_crossing cross_pair(logic [InBytes*8-1:0] w, logic [3:0] u);
        t_crossing r;
        t_shape    p, q;
        t_extent   ep, eq, ov;
        longint    xn, yn, d, m;
        bit        hit, endless, vert, same;
        p = shape_from({w[63:0], u[1:0]});
        q = shape_from({w[127:64], u[3:2]});
        xn = 0; yn = 0; d = 0; hit = 0; endless = 0;
        if ((p.a != 0 || p.b != 0) && (q.a != 0 || q.b != 0)) begin
            m = p.a * q.b - q.a * p.b;
            if (m != 0) begin
                xn = q.c * p.b - p.c * q.b;
                yn = p.c * q.a - q.c * p.a;
                d = m;
                if (d < 0) begin
                    d = -d; xn = -xn; yn = -yn;
                end
                hit = on_shape(p, xn, yn, d) && on_shape(q, xn, yn, d);
            end else begin
                same = (p.b != 0) ? (p.b * q.c == p.c * q.b) : (p.a * q.c == p.c * q.a);
                if (same) begin
                    if (p.kind == K_LINE || q.kind == K_LINE) begin
                        endless = 1;
                    end else begin
                        vert = (p.b == 0);
                        ep = extent_of(p, vert);
                        eq = extent_of(q, vert);
                        ov = ep;
                        if (!ep.has_lo || (eq.has_lo && eq.lo > ep.lo)) begin
                            ov.has_lo = eq.has_lo; ov.lo = eq.lo;
                            ov.lo_x = eq.lo_x; ov.lo_y = eq.lo_y;
                        end
                        if (!ep.has_hi || (eq.has_hi && eq.hi < ep.hi)) begin
                            ov.has_hi = eq.has_hi; ov.hi = eq.hi;
                            ov.hi_x = eq.hi_x; ov.hi_y = eq.hi_y;
                        end
                        if (!ov.has_lo || !ov.has_hi || ov.lo < ov.hi) begin
                            endless = 1;
                        end else if (ov.lo == ov.hi) begin
                            hit = 1; xn = ov.lo_x; yn = ov.lo_y; d = 1;
                        end
                    end
                end
            end
        end
        if (!hit) begin
            xn = 0; yn = 0; d = 0;
        end
        r.hit = hit;
        r.endless = endless;
        r.xn = xn[NumBits-1:0];
        r.yn = yn[NumBits-1:0];
        r.den = d[DenBits-1:0];
        return r;
    endfunction

    assign o_pending = crossings_due.size();

    // watch both channels at each edge
    always @(posedge i_clk) begin
        t_crossing want, got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                crossings_due.insert(crossings_due.size(), cross_pair(i_in_data, i_in_user));
            if (i_out_valid && i_out_ready) begin
                got.hit = i_out_user[0];
                got.endless = i_out_user[1];
                got.xn = i_out_data[NumBits-1:0];
                got.yn = i_out_data[2*NumBits-1:NumBits];
                got.den = i_out_data[2*NumBits+DenBits-1:2*NumBits];
                if (crossings_due.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected output word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = crossings_due.pop_front();
                    if (got !== want || i_out_data[OutBytes*8-1:OutBits] !== '0) begin
                        if (o_fail_count < 10)
                            $display("mismatch: hit %b/%b inf %b/%b x %h/%h y %h/%h d %h/%h",
                                     want.hit, got.hit, want.endless, got.endless,
                                     want.xn, got.xn, want.yn, got.yn, want.den, got.den);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

### tb/tb_line_ray_segment_intersection.sv
// testbench top: stimulus, idling and verdict for the intersection block
`timescale 1ns / 100ps
`default_nettype none
module tb_line_ray_segment_intersection;
    import lrsi_pkg::*;

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   in_valid = 0;
    logic                   in_ready;
    logic [InBytes*8-1:0]   in_data = '0;
    logic [3:0]             in_user = '0;
    logic                   out_valid;
    logic                   out_ready = 0;
    logic [OutBytes*8-1:0]  out_data;
    logic [1:0]             out_user;
    int                     fail_count;
    int                     pending;
    bit                     feeding_done = 0;

    line_ray_segment_intersection i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready), .s_axis_tdata(in_data),
        .s_axis_tuser(in_user),
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
        .m_axis_tdata(out_data), .m_axis_tuser(out_user)
    );

    tb_lrsi_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_in_user(in_user),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .i_out_user(out_user),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    // build one object slice
    function automatic logic [65:0] shape_word(t_kind k, logic [15:0] ax, logic [15:0] ay,
                                               logic [15:0] bx, logic [15:0] by);
        return {by, bx, ay, ax, k};
    endfunction

    function automatic logic [15:0] rand_coord(int span);
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return (span == 0) ? 16'($urandom_range(0, 1) ? 16'h8000 : 16'h7fff)
                                  : 16'($urandom_range(0, 2 * span) - span);
            default: return 16'($urandom_range(0, 2 * span) - span);
        endcase
    endfunction

    // random pair, often collinear or sharing points so the special cases show up
    function automatic logic [131:0] random_pair();
        logic [65:0] p, q;
        logic [15:0] ax, ay, bx, by, dx, dy;
        int          span, t0, t1;
        span = $urandom_range(0, 1) ? 8 : ($urandom_range(0, 3) == 0 ? 0 : 2000);
        ax = rand_coord(span); ay = rand_coord(span);
        bx = rand_coord(span); by = rand_coord(span);
        p = shape_word(t_kind'($urandom_range(0, 3)), ax, ay, bx, by);
        case ($urandom_range(0, 4))
            0, 1: begin
                // same direction line through p
                dx = 16'($urandom_range(0, 6) - 3); dy = 16'($urandom_range(0, 6) - 3);
                t0 = $urandom_range(0, 8) - 4; t1 = $urandom_range(0, 8) - 4;
                q = shape_word(t_kind'($urandom_range(0, 3)),
                               ax + 16'(t0) * dx, ay + 16'(t0) * dy,
                               ax + 16'(t1) * dx, ay + 16'(t1) * dy);
                p = shape_word(t_kind'($urandom_range(0, 3)), ax, ay, ax + dx, ay + dy);
            end
            2: q = shape_word(t_kind'($urandom_range(0, 3)), bx, by,
                              rand_coord(span), rand_coord(span));
            default: q = shape_word(t_kind'($urandom_range(0, 3)), rand_coord(span),
                                    rand_coord(span), rand_coord(span), rand_coord(span));
        endcase
        return {q, p};
    endfunction

    // split a pair into coordinates for tdata and kinds for tuser
    task automatic send_word(logic [131:0] w);
        in_valid <= 1;
        in_data <= {w[131:68], w[65:2]};
        in_user <= {w[67:66], w[1:0]};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        int phase;
        phase = int'(($time / 8) % 97);
        if (phase < 30) out_ready <= 1;
        else out_ready <= ($urandom_range(0, 2) != 0) && !(phase > 80 && phase < 86);
    end

    initial begin
        logic [131:0] directed[$];
        logic [131:0] w;
        int           gap, burst, wait_cycles;
        // directed cases
        directed.insert(directed.size(),
            {shape_word(K_SEG, 0, 10, 10, 0), shape_word(K_SEG, 0, 0, 10, 10)});
        directed.insert(directed.size(),
            {shape_word(K_LINE, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000),
             shape_word(K_LINE, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff)});
        directed.insert(directed.size(),
            {shape_word(K_RAY, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff),
             shape_word(K_RAY, 16'h8000, 16'h8000, 16'h7fff, 16'h7ffe)});
        directed.insert(directed.size(),
            {shape_word(K_SEG3, 0, 5, 0, -5), shape_word(K_SEG3, -5, 0, 5, 0)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 0, 0, 9, 9), shape_word(K_SEG, 3, 3, 3, 3)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 0, 1, 5, 6), shape_word(K_SEG, 0, 0, 5, 5)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 2, 2, 7, 7), shape_word(K_LINE, 0, 0, 1, 1)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 4, 4, 7, 7), shape_word(K_SEG, 0, 0, 3, 3)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 3, 3, 7, 7), shape_word(K_SEG, 0, 0, 3, 3)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 2, 2, 7, 7), shape_word(K_SEG, 0, 0, 3, 3)});
        directed.insert(directed.size(),
            {shape_word(K_RAY, 0, 0, 0, -4), shape_word(K_RAY, 0, 0, 0, 4)});
        directed.insert(directed.size(),
            {shape_word(K_RAY, 0, 1, 0, 4), shape_word(K_RAY, 0, 0, 0, -4)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 0, 0, 0, 4), shape_word(K_RAY, 0, 4, 0, 9)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 20, 0, 20, 5), shape_word(K_SEG, 0, 0, 10, 0)});
        directed.insert(directed.size(),
            {shape_word(K_RAY, 5, 1, 9, 1), shape_word(K_RAY, 0, 0, 3, 0)});
        directed.insert(directed.size(),
            {shape_word(K_RAY, -3, 7, 0, 0), shape_word(K_RAY, 7, -3, 0, 0)});
        directed.insert(directed.size(),
            {shape_word(K_LINE, 1, 3, 2, 5), shape_word(K_SEG, 1, 3, 2, 5)});
        directed.insert(directed.size(),
            {shape_word(K_SEG, 16'hffff, 16'hffff, 16'hffff, 16'hffff),
             shape_word(K_LINE, 16'hffff, 16'hffff, 16'hffff, 16'hffff)});
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        foreach (directed[i]) send_word(directed[i]);
        in_valid <= 0;
        for (int n = 0; n < 1900; ) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++, n++) begin
                w = random_pair();
                send_word(w);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_valid <= 0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // overall time limit
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
rtl/lrsi_pkg.sv
rtl/line_ray_segment_intersection.sv
rtl/lrsi_checker.sv
tb/tb_lrsi_checker.sv
tb/tb_line_ray_segment_intersection.sv
